@@ rtl/bdtr_pkg.sv @@
// ----------------------------------------------------------------------------
// bdtr_pkg
// shared types, glyph table and row assembly for the big-digit renderer
// ----------------------------------------------------------------------------
package bdtr_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK_BYTE  = 8'h20;
  localparam logic [7:0] DEGREE_BYTE = 8'h6f;
  localparam logic [7:0] POINT_BYTE  = 8'hd2;

  localparam logic [3:0] GLYPH_C     = 4'd10;
  localparam logic [3:0] GLYPH_MINUS = 4'd11;
  localparam logic [3:0] GLYPH_LAST  = 4'd11;

  localparam logic [1:0] ROW_TOP    = 2'd0;
  localparam logic [1:0] ROW_BOTTOM = 2'd3;

  // largest magnitude that can be drawn, in hundredths
  localparam logic [14:0] MAG_LIMIT = 15'd9999;

  localparam int unsigned ROW_BITS = 160;

  // decoded item handed from the front end to the row generator
  typedef struct packed {
    logic       oor;
    logic       neg;
    logic [3:0] d0;   // tens
    logic [3:0] d1;   // units
    logic [3:0] d2;   // tenths
    logic [3:0] d3;   // hundredths
  } entry_t;

  // one glyph row per entry, index {glyph, row}; leftmost column in the low byte
  localparam logic [23:0] GLYPH_ROM [0:47] = '{
    24'h020100, 24'h1f201f, 24'h1f201f, 24'h070605,   // 0
    24'h200100, 24'h201f20, 24'h201f20, 24'h060606,   // 1
    24'h020100, 24'h030100, 24'h20201f, 24'h060606,   // 2
    24'h020100, 24'h030020, 24'h040520, 24'h070605,   // 3
    24'h012000, 24'h1f201f, 24'h1f0606, 24'h062020,   // 4
    24'h010101, 24'h02011f, 24'h1f2020, 24'h070606,   // 5
    24'h020100, 24'h02011f, 24'h1f201f, 24'h070605,   // 6
    24'h010101, 24'h030020, 24'h201f20, 24'h200620,   // 7
    24'h020100, 24'h1f011f, 24'h1f201f, 24'h070605,   // 8
    24'h020100, 24'h1f011f, 24'h1f2020, 24'h070605,   // 9
    24'h020100, 24'h20201f, 24'h20201f, 24'h070605,   // c
    24'h202020, 24'h202020, 24'h060606, 24'h202020    // minus
  };

  function automatic logic [23:0] glyph_bits(logic [3:0] g, logic [1:0] r);
    logic [5:0] idx;
    idx = {g, r};
    if (g > GLYPH_LAST) begin
      glyph_bits = {3{BLANK_BYTE}};
    end else begin
      glyph_bits = GLYPH_ROM[idx];
    end
  endfunction

  // all 20 bytes of one display row, column 0 in bits 7:0
  function automatic logic [ROW_BITS-1:0] render_row(entry_t e, logic [1:0] r);
    logic [ROW_BITS-1:0] row;
    row = {20{BLANK_BYTE}};
    if (e.neg) begin
      row[0 +: 24] = glyph_bits(GLYPH_MINUS, r);
    end
    row[24  +: 24] = glyph_bits(e.d0, r);
    row[48  +: 24] = glyph_bits(e.d1, r);
    row[80  +: 24] = glyph_bits(e.d2, r);
    row[104 +: 24] = glyph_bits(e.d3, r);
    row[136 +: 24] = glyph_bits(GLYPH_C, r);
    if (r == ROW_BOTTOM) begin
      row[72 +: 8] = POINT_BYTE;
    end
    if (r == ROW_TOP) begin
      row[128 +: 8] = DEGREE_BYTE;
    end
    if (e.oor) begin
      row = '0;
    end
    render_row = row;
  endfunction

endpackage

@@ rtl/bdtr_front.sv @@
// ----------------------------------------------------------------------------
// bdtr_front
// four-stage pipe: magnitude and range check, then decimal digit split
// ----------------------------------------------------------------------------
module bdtr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [14:0]    in_temp_hundredths,
  output logic                  push,
  output bdtr_pkg::entry_t      push_data,
  input  logic                  q_full
);

  logic        adv;

  // stage 1: sign, magnitude, range
  logic        s1_v_r;
  logic        s1_neg_r, s1_oor_r;
  logic [14:0] s1_mag_r;
  logic [14:0] mag_nxt;

  // stage 2: hundreds part (mag / 100)
  logic        s2_v_r;
  logic        s2_neg_r, s2_oor_r;
  logic [14:0] s2_mag_r;
  logic [6:0]  s2_hi_r;
  logic [27:0] hi_prod;

  // stage 3: remainder (mag % 100)
  logic        s3_v_r;
  logic        s3_neg_r, s3_oor_r;
  logic [6:0]  s3_hi_r, s3_lo_r;
  logic [14:0] lo_full;

  // stage 4: tens digit of each half
  logic        s4_v_r;
  logic        s4_neg_r, s4_oor_r;
  logic [6:0]  s4_hi_r, s4_lo_r;
  logic [3:0]  s4_dhi_r, s4_dlo_r;
  logic [14:0] dhi_prod, dlo_prod;
  logic [6:0]  rhi, rlo;

  assign adv      = !s4_v_r || !q_full;
  assign in_stall = !adv;

  assign mag_nxt = in_temp_hundredths[14] ? (15'd0 - in_temp_hundredths) : in_temp_hundredths;
  assign hi_prod = {13'd0, s1_mag_r} * 28'd5243;
  assign lo_full = s2_mag_r - {8'd0, s2_hi_r} * 15'd100;
  assign dhi_prod = {8'd0, s3_hi_r} * 15'd205;
  assign dlo_prod = {8'd0, s3_lo_r} * 15'd205;

  // units and hundredths: remainder after the tens digit
  assign rhi = s4_hi_r - {3'd0, s4_dhi_r} * 7'd10;
  assign rlo = s4_lo_r - {3'd0, s4_dlo_r} * 7'd10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r <= in_temp_hundredths[14];
      s1_mag_r <= mag_nxt;
      s1_oor_r <= (mag_nxt > bdtr_pkg::MAG_LIMIT);

      s2_neg_r <= s1_neg_r;
      s2_oor_r <= s1_oor_r;
      s2_mag_r <= s1_mag_r;
      s2_hi_r  <= hi_prod[25:19];

      s3_neg_r <= s2_neg_r;
      s3_oor_r <= s2_oor_r;
      s3_hi_r  <= s2_hi_r;
      s3_lo_r  <= lo_full[6:0];

      s4_neg_r <= s3_neg_r;
      s4_oor_r <= s3_oor_r;
      s4_hi_r  <= s3_hi_r;
      s4_lo_r  <= s3_lo_r;
      s4_dhi_r <= dhi_prod[14:11];
      s4_dlo_r <= dlo_prod[14:11];
    end
  end

  assign push           = s4_v_r && !q_full;
  assign push_data.oor  = s4_oor_r;
  assign push_data.neg  = s4_neg_r;
  assign push_data.d0   = s4_dhi_r;
  assign push_data.d1   = rhi[3:0];
  assign push_data.d2   = s4_dlo_r;
  assign push_data.d3   = rlo[3:0];

endmodule

@@ rtl/bdtr_queue.sv @@
// ----------------------------------------------------------------------------
// bdtr_queue
// small fifo of decoded items between front end and row generator
// ----------------------------------------------------------------------------
module bdtr_queue #(
  parameter int unsigned DEPTH = bdtr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdtr_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bdtr_pkg::entry_t  head_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  bdtr_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/bdtr_back.sv @@
// ----------------------------------------------------------------------------
// bdtr_back
// row generator: one display row per cycle, while the output is not stalled, from the queue head
// ----------------------------------------------------------------------------
module bdtr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  bdtr_pkg::entry_t  head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_row_index,
  output logic [63:0]       out_bytes_low,
  output logic [63:0]       out_bytes_mid,
  output logic [31:0]       out_bytes_high,
  output logic              out_out_of_range,
  output logic              out_last_row
);

  logic                          out_valid_r;
  logic [1:0]                    row_r;
  logic [1:0]                    row_idx_r;
  logic [bdtr_pkg::ROW_BITS-1:0] bytes_r;
  logic                          oor_r, last_r;
  logic                          fire, last;

  assign fire = head_valid && (!out_valid_r || !out_stall);
  assign last = head_data.oor || (row_r == bdtr_pkg::ROW_BOTTOM);
  assign pop  = fire && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_r       <= bdtr_pkg::ROW_TOP;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        row_r       <= last ? bdtr_pkg::ROW_TOP : row_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      row_idx_r <= head_data.oor ? bdtr_pkg::ROW_TOP : row_r;
      bytes_r   <= bdtr_pkg::render_row(head_data, row_r);
      oor_r     <= head_data.oor;
      last_r    <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = row_idx_r;
  assign out_bytes_low    = bytes_r[63:0];
  assign out_bytes_mid    = bytes_r[127:64];
  assign out_bytes_high   = bytes_r[159:128];
  assign out_out_of_range = oor_r;
  assign out_last_row     = last_r;

endmodule

@@ rtl/big_digit_temperature_renderer_core.sv @@
// ----------------------------------------------------------------------------
// big_digit_temperature_renderer_core
// draws a signed temperature as 3x4 big glyphs, one 20-byte row per word
// ----------------------------------------------------------------------------
// the first row word follows the input through the front-end stages, queue
//   and row generator output register; an in-range word gives four row
//   words, one row per cycle while the output is not stalled, an out-of-range
//   word gives one; input is taken every cycle while the queue has room
// reset: synchronous active-low rst_n empties the pipe, queue and output
module big_digit_temperature_renderer_core #(
  parameter int unsigned QUEUE_DEPTH = bdtr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] in_temp_hundredths,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic [63:0]        out_bytes_low,
  output logic [63:0]        out_bytes_mid,
  output logic [31:0]        out_bytes_high,
  output logic               out_out_of_range,
  output logic               out_last_row
);

  // front end to queue
  logic             push;
  logic             q_full;
  bdtr_pkg::entry_t push_data;

  // queue to row generator
  logic             pop;
  logic             head_valid;
  bdtr_pkg::entry_t head_data;

  // front end: sign/magnitude, range check, digit split by reciprocal multiply
  bdtr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temp_hundredths (in_temp_hundredths),
    .push               (push),
    .push_data          (push_data),
    .q_full             (q_full)
  );

  // decouples digit decode from row output so each side stalls on its own
  bdtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // back end: rows 0..3 of the head item (one if out of range), then pops it
  bdtr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_index    (out_row_index),
    .out_bytes_low    (out_bytes_low),
    .out_bytes_mid    (out_bytes_mid),
    .out_bytes_high   (out_bytes_high),
    .out_out_of_range (out_out_of_range),
    .out_last_row     (out_last_row)
  );

endmodule

@@ bench/tb_big_digit_temperature_renderer_core.sv @@
// ----------------------------------------------------------------------------
// tb_big_digit_temperature_renderer_core
// self-checking bench for the big-digit temperature renderer: directed values
// at the range edges and for every digit, then random temperatures, with
// random idle gaps on the input and random stalls on the row output
// ----------------------------------------------------------------------------
module tb_big_digit_temperature_renderer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // one expected row word
  typedef struct {
    logic [1:0]  row_index;
    logic [63:0] bytes_low;
    logic [63:0] bytes_mid;
    logic [31:0] bytes_high;
    logic        out_of_range;
    logic        last_row;
  } row_word_t;

  // glyph art as read on screen, leftmost column in the top byte
  localparam logic [23:0] GLYPH_ART [0:47] = '{
    24'h000102, 24'h1f201f, 24'h1f201f, 24'h050607,   // 0
    24'h000120, 24'h201f20, 24'h201f20, 24'h060606,   // 1
    24'h000102, 24'h000103, 24'h1f2020, 24'h060606,   // 2
    24'h000102, 24'h200003, 24'h200504, 24'h050607,   // 3
    24'h002001, 24'h1f201f, 24'h06061f, 24'h202006,   // 4
    24'h010101, 24'h1f0102, 24'h20201f, 24'h060607,   // 5
    24'h000102, 24'h1f0102, 24'h1f201f, 24'h050607,   // 6
    24'h010101, 24'h200003, 24'h201f20, 24'h200620,   // 7
    24'h000102, 24'h1f011f, 24'h1f201f, 24'h050607,   // 8
    24'h000102, 24'h1f011f, 24'h20201f, 24'h050607,   // 9
    24'h000102, 24'h1f2020, 24'h1f2020, 24'h050607,   // c
    24'h202020, 24'h202020, 24'h060606, 24'h202020    // minus
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [14:0] in_temp_hundredths = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_row_index;
  logic [63:0]        out_bytes_low;
  logic [63:0]        out_bytes_mid;
  logic [31:0]        out_bytes_high;
  logic               out_out_of_range;
  logic               out_last_row;

  row_word_t   expected_rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  // when set, neither side idles: back-to-back words
  bit          no_idle = 1'b0;

  big_digit_temperature_renderer_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temp_hundredths (in_temp_hundredths),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_index      (out_row_index),
    .out_bytes_low      (out_bytes_low),
    .out_bytes_mid      (out_bytes_mid),
    .out_bytes_high     (out_bytes_high),
    .out_out_of_range   (out_out_of_range),
    .out_last_row       (out_last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // glyph row with column 0 moved to the low byte
  function automatic logic [23:0] glyph_cols(int unsigned g, int unsigned r);
    logic [23:0] art;
    art = GLYPH_ART[g * 4 + r];
    glyph_cols = {art[7:0], art[15:8], art[23:16]};
  endfunction

  // work out the row words one temperature should produce
  task automatic draw_temperature(input logic signed [14:0] t);
    logic         neg;
    logic [15:0]  mag;
    int unsigned  d_tens, d_units, d_tenths, d_hundredths;
    logic [159:0] row;
    row_word_t    w;
    neg = t[14];
    // two's complement magnitude, -16384 gives 16384
    mag = neg ? (16'h8000 - {1'b0, t}) : {1'b0, t};
    if (mag > {1'b0, bdtr_pkg::MAG_LIMIT}) begin
      // too big to draw: one flagged word, no bytes
      w.row_index    = bdtr_pkg::ROW_TOP;
      w.bytes_low    = '0;
      w.bytes_mid    = '0;
      w.bytes_high   = '0;
      w.out_of_range = 1'b1;
      w.last_row     = 1'b1;
      expected_rows.push_back(w);
    end else begin
      d_tens       = mag / 1000;
      d_units      = (mag / 100) % 10;
      d_tenths     = (mag / 10) % 10;
      d_hundredths = mag % 10;
      for (int r = 0; r < 4; r++) begin
        row = {20{bdtr_pkg::BLANK_BYTE}};
        // zero is not negative, so the sign columns stay blank
        if (neg) row[0 +: 24] = glyph_cols(bdtr_pkg::GLYPH_MINUS, r);
        // leading zero is drawn in the tens place
        row[24  +: 24] = glyph_cols(d_tens, r);
        row[48  +: 24] = glyph_cols(d_units, r);
        row[80  +: 24] = glyph_cols(d_tenths, r);
        row[104 +: 24] = glyph_cols(d_hundredths, r);
        row[136 +: 24] = glyph_cols(bdtr_pkg::GLYPH_C, r);
        if (r == bdtr_pkg::ROW_BOTTOM) row[72 +: 8] = bdtr_pkg::POINT_BYTE;
        if (r == bdtr_pkg::ROW_TOP) row[128 +: 8] = bdtr_pkg::DEGREE_BYTE;
        w.row_index    = r[1:0];
        w.bytes_low    = row[63:0];
        w.bytes_mid    = row[127:64];
        w.bytes_high   = row[159:128];
        w.out_of_range = 1'b0;
        w.last_row     = (r == bdtr_pkg::ROW_BOTTOM);
        expected_rows.push_back(w);
      end
    end
  endtask

  // offer one temperature word after a random gap, return once it is taken
  task automatic send_temperature(input logic signed [14:0] t);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_temp_hundredths <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    draw_temperature(t);
  endtask

  // random temperature that can be drawn
  function automatic logic signed [14:0] drawable_temperature();
    int v;
    v = int'($urandom_range(0, 19998)) - 9999;
    drawable_temperature = v[14:0];
  endfunction

  // result side: stall for a random count after every accepted row word
  always @(posedge clk) begin
    int unsigned n;
    static int unsigned stall_left = 0;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      stall_left = n;
      out_stall <= (n > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  // compare every accepted row word with the oldest expected one
  always @(posedge clk) begin
    row_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $error("row word with nothing expected, row_index %0d", out_row_index);
        mismatches++;
      end else begin
        w = expected_rows.pop_front();
        if (out_row_index !== w.row_index) begin
          $error("row_index expected %0d actual %0d", w.row_index, out_row_index);
          mismatches++;
        end
        if (out_bytes_low !== w.bytes_low) begin
          $error("bytes_low expected %h actual %h", w.bytes_low, out_bytes_low);
          mismatches++;
        end
        if (out_bytes_mid !== w.bytes_mid) begin
          $error("bytes_mid expected %h actual %h", w.bytes_mid, out_bytes_mid);
          mismatches++;
        end
        if (out_bytes_high !== w.bytes_high) begin
          $error("bytes_high expected %h actual %h", w.bytes_high, out_bytes_high);
          mismatches++;
        end
        if (out_out_of_range !== w.out_of_range) begin
          $error("out_of_range expected %0b actual %0b", w.out_of_range,
                 out_out_of_range);
          mismatches++;
        end
        if (out_last_row !== w.last_row) begin
          $error("last_row expected %0b actual %0b", w.last_row, out_last_row);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // range edges, zero, sign and the out-of-range boundary
  task automatic test_range_extremes();
    logic signed [14:0] vals[$];
    vals = '{15'sd0, 15'sd1, -15'sd1, 15'sd9999, -15'sd9999, 15'sd10000,
             -15'sd10000, 15'sd16383, -15'sd16384, 15'sd99, -15'sd5, 15'sd1000};
    foreach (vals[i]) send_temperature(vals[i]);
  endtask

  // every digit glyph in every place, both signs
  task automatic test_each_digit();
    for (int d = 0; d < 10; d++) begin
      send_temperature((d % 2) ? -15'(d * 1111) : 15'(d * 1111));
    end
    send_temperature(15'sd1234);
    send_temperature(-15'sd5678);
  endtask

  // mostly drawable values, a few out of range, a stretch with no idling
  task automatic test_random_drawable();
    int v;
    for (int i = 0; i < 250; i++) begin
      no_idle = (i >= 100 && i < 140);
      if ($urandom_range(0, 9) == 0) begin
        v = int'($urandom_range(10000, 16383));
        if ($urandom_range(0, 1) == 1) v = -v;
        send_temperature(v[14:0]);
      end else begin
        send_temperature(drawable_temperature());
      end
    end
    no_idle = 1'b0;
  endtask

  // the whole 15-bit input space, so every bit toggles
  task automatic test_random_full_span();
    for (int i = 0; i < 100; i++) begin
      send_temperature(15'($urandom_range(0, 32767)));
    end
  endtask

  // both sides at full rate, mixed in-range and flagged words
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 50; i++) begin
      if (i % 5 == 4) send_temperature(15'($urandom_range(10000, 16383)));
      else send_temperature(drawable_temperature());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_extremes();
    test_each_digit();
    test_random_drawable();
    test_random_full_span();
    test_back_to_back();

    in_valid <= 1'b0;
    // drain, then give the pipe time to show any stray word
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
